>>> design/mbc3m_pkg.sv
package mbc3m_pkg;

   // result action codes
   localparam logic [2:0] ACT_HOST  = 3'd0;
   localparam logic [2:0] ACT_IO    = 3'd1;
   localparam logic [2:0] ACT_BANK  = 3'd2;
   localparam logic [2:0] ACT_ZERO  = 3'd3;
   localparam logic [2:0] ACT_DROP  = 3'd4;
   localparam logic [2:0] ACT_FAULT = 3'd5;

   // configuration register indexes
   localparam logic [2:0] CSR_ROM_BASE  = 3'd0;
   localparam logic [2:0] CSR_RAM_BASE  = 3'd1;
   localparam logic [2:0] CSR_VRAM_BASE = 3'd2;
   localparam logic [2:0] CSR_WRAM_BASE = 3'd3;
   localparam logic [2:0] CSR_HRAM_BASE = 3'd4;
   localparam logic [2:0] CSR_MBC_KIND  = 3'd5;

   localparam logic [31:0] ROM_BASE_RESET  = 32'h0800_0000;
   localparam logic [31:0] RAM_BASE_RESET  = 32'h0A00_0000;
   localparam logic [31:0] VRAM_BASE_RESET = 32'h0230_0000;
   localparam logic [31:0] WRAM_BASE_RESET = 32'h0300_0000;
   localparam logic [31:0] HRAM_BASE_RESET = 32'h0000_0000;

   localparam logic [2:0] MBC_KIND_MBC3 = 3'd3;

   // bank register select, address bits 14:13 of a ROM-space write
   localparam logic [1:0] SEL_RAM_ENABLE = 2'b00;
   localparam logic [1:0] SEL_ROM_BANK   = 2'b01;
   localparam logic [1:0] SEL_RAM_BANK   = 2'b10;
   localparam logic [1:0] SEL_CLK_LATCH  = 2'b11;

   localparam logic [7:0] RAM_ENABLE_KEY = 8'h0A;
   localparam logic [7:0] RTC_BANK_LO    = 8'd8;
   localparam logic [7:0] RTC_BANK_HI    = 8'd12;
   localparam logic [7:0] RAM_BANK_COUNT = 8'd4;

   localparam logic [31:0] WRAM_HI_OFFSET = 32'h0000_1000;

   typedef struct packed {
      logic [31:0] rom_start;
      logic [31:0] ram_start;
      logic [31:0] vram_base;
      logic [31:0] wram_base;
      logic [31:0] hram_base;
      logic [2:0]  mbc_kind;
   } cfg_type;

   typedef struct packed {
      logic [7:0] rom_bank;
      logic [7:0] ram_bank;
      logic       ram_on;
      logic       ram_mapped;
   } bank_state_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] sel;
      logic [7:0] data;
   } bank_wr_type;

   typedef struct packed {
      logic        mode;
      logic [15:0] address;
      logic [7:0]  write_data;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [31:0] host_address;
      logic [7:0]  io_port;
      logic [7:0]  store_data;
   } rsp_word_type;

endpackage

>>> design/mbc3m_intf.sv
interface mbc3m_req_intf;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [15:0] address;
   logic [7:0]  write_data;

   modport source (output valid, mode, address, write_data, input ready);
   modport sink   (input valid, mode, address, write_data, output ready);
endinterface

interface mbc3m_rsp_intf;
   logic        valid;
   logic        ready;
   logic [2:0]  action;
   logic [31:0] host_address;
   logic [7:0]  io_port;
   logic [7:0]  store_data;

   modport source (output valid, action, host_address, io_port, store_data, input ready);
   modport sink   (input valid, action, host_address, io_port, store_data, output ready);
endinterface

interface mbc3m_csr_intf;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [31:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

>>> design/mbc3m_csr_regs.sv
module mbc3m_csr_regs (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic [2:0]         wr_index,
   input  logic [31:0]        wr_data,
   output mbc3m_pkg::cfg_type cfg
);

   mbc3m_pkg::cfg_type cfg_ff;
   mbc3m_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            mbc3m_pkg::CSR_ROM_BASE:  cfg_in.rom_start = wr_data;
            mbc3m_pkg::CSR_RAM_BASE:  cfg_in.ram_start = wr_data;
            mbc3m_pkg::CSR_VRAM_BASE: cfg_in.vram_base = wr_data;
            mbc3m_pkg::CSR_WRAM_BASE: cfg_in.wram_base = wr_data;
            mbc3m_pkg::CSR_HRAM_BASE: cfg_in.hram_base = wr_data;
            mbc3m_pkg::CSR_MBC_KIND:  cfg_in.mbc_kind  = wr_data[2:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rom_start <= mbc3m_pkg::ROM_BASE_RESET;
         cfg_ff.ram_start <= mbc3m_pkg::RAM_BASE_RESET;
         cfg_ff.vram_base <= mbc3m_pkg::VRAM_BASE_RESET;
         cfg_ff.wram_base <= mbc3m_pkg::WRAM_BASE_RESET;
         cfg_ff.hram_base <= mbc3m_pkg::HRAM_BASE_RESET;
         cfg_ff.mbc_kind  <= mbc3m_pkg::MBC_KIND_MBC3;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> design/mbc3m_bank_state.sv
module mbc3m_bank_state (
   input  logic                      clock,
   input  logic                      reset,
   input  mbc3m_pkg::bank_wr_type    bank_wr,
   output mbc3m_pkg::bank_state_type bank
);

   mbc3m_pkg::bank_state_type bank_ff;
   mbc3m_pkg::bank_state_type bank_in;

   always_comb begin
      bank_in = bank_ff;
      if (bank_wr.valid) begin
         case (bank_wr.sel)
            mbc3m_pkg::SEL_RAM_ENABLE: begin
               if (bank_wr.data == 8'd0) begin
                  bank_in.ram_on = 1'b0;
               end else if (bank_wr.data == mbc3m_pkg::RAM_ENABLE_KEY) begin
                  bank_in.ram_on     = 1'b1;
                  bank_in.ram_mapped = (bank_ff.ram_bank < mbc3m_pkg::RAM_BANK_COUNT);
               end
            end
            mbc3m_pkg::SEL_ROM_BANK: begin
               bank_in.rom_bank = (bank_wr.data != 8'd0) ? bank_wr.data : 8'd1;
            end
            mbc3m_pkg::SEL_RAM_BANK: begin
               if (bank_wr.data >= mbc3m_pkg::RTC_BANK_LO) begin
                  bank_in.ram_bank   = bank_wr.data;
                  bank_in.ram_mapped = 1'b0;
               end else if (bank_wr.data < mbc3m_pkg::RAM_BANK_COUNT) begin
                  bank_in.ram_bank   = bank_wr.data;
                  bank_in.ram_mapped = bank_ff.ram_on;
               end else begin
                  bank_in.ram_mapped = 1'b0;
               end
            end
            mbc3m_pkg::SEL_CLK_LATCH: ;  // latch has no effect here
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bank_ff.rom_bank   <= 8'd1;
         bank_ff.ram_bank   <= 8'd0;
         bank_ff.ram_on     <= 1'b0;
         bank_ff.ram_mapped <= 1'b1;
      end else begin
         bank_ff <= bank_in;
      end
   end

   assign bank = bank_ff;

endmodule

>>> design/mbc3m_translate.sv
module mbc3m_translate (
   input  mbc3m_pkg::cfg_type        cfg,
   input  mbc3m_pkg::bank_state_type bank,
   input  mbc3m_pkg::req_word_type   req_word,
   output mbc3m_pkg::rsp_word_type   rsp_word,
   output mbc3m_pkg::bank_wr_type    bank_wr
);

   logic [3:0]  ix;
   logic [11:0] off;
   logic        wr;
   logic        is_mbc3;
   logic        rtc_bank;
   logic [31:0] base;
   logic [31:0] offset;
   logic [2:0]  action;
   logic [7:0]  port;

   assign ix       = req_word.address[15:12];
   assign off      = req_word.address[11:0];
   assign wr       = req_word.mode;
   assign is_mbc3  = (cfg.mbc_kind == mbc3m_pkg::MBC_KIND_MBC3);
   assign rtc_bank = (bank.ram_bank >= mbc3m_pkg::RTC_BANK_LO) &&
                     (bank.ram_bank <= mbc3m_pkg::RTC_BANK_HI);

   always_comb begin
      action = mbc3m_pkg::ACT_HOST;
      port   = 8'd0;
      base   = cfg.hram_base;
      offset = {23'd0, off[8:0]};
      if (ix < 4'd4) begin
         base   = cfg.rom_start;
         offset = {18'd0, req_word.address[13:0]};
      end else if (ix < 4'd8) begin
         base   = cfg.rom_start;
         offset = {10'd0, bank.rom_bank, req_word.address[13:0]};
      end else if (ix < 4'd10) begin
         base   = cfg.vram_base;
         offset = {19'd0, req_word.address[12:0]};
      end else if (ix < 4'd12) begin
         base   = cfg.ram_start;
         offset = {11'd0, bank.ram_bank, req_word.address[12:0]};
         if (!bank.ram_mapped) begin
            if (!is_mbc3) begin
               action = mbc3m_pkg::ACT_FAULT;
            end else if (wr) begin
               action = rtc_bank ? mbc3m_pkg::ACT_DROP : mbc3m_pkg::ACT_FAULT;
            end else if (!bank.ram_on) begin
               action = mbc3m_pkg::ACT_ZERO;
            end else begin
               action = rtc_bank ? mbc3m_pkg::ACT_ZERO : mbc3m_pkg::ACT_FAULT;
            end
         end
      end else if (ix < 4'd14) begin
         base   = cfg.wram_base;
         offset = {19'd0, req_word.address[12:0]};
      end else if (ix == 4'd14) begin
         base   = cfg.wram_base;
         offset = {20'd0, off};
      end else if (off < 12'hE00) begin
         base   = cfg.wram_base;
         offset = mbc3m_pkg::WRAM_HI_OFFSET + {20'd0, off};
      end else if (wr && off >= 12'hF00 && off < 12'hF80) begin
         action = mbc3m_pkg::ACT_IO;
         port   = off[7:0];
      end

      // ROM-space writes program the bank registers on MBC3; on other kinds they fault
      if (wr && ix < 4'd8) begin
         action = is_mbc3 ? mbc3m_pkg::ACT_BANK : mbc3m_pkg::ACT_FAULT;
      end
   end

   assign bank_wr.valid = wr && (ix < 4'd8) && is_mbc3;
   assign bank_wr.sel   = req_word.address[14:13];
   assign bank_wr.data  = req_word.write_data;

   assign rsp_word.action       = action;
   assign rsp_word.host_address = (action == mbc3m_pkg::ACT_HOST) ? (base + offset) : 32'd0;
   assign rsp_word.io_port      = port;
   assign rsp_word.store_data   = (wr && action != mbc3m_pkg::ACT_FAULT) ?
                                  req_word.write_data : 8'd0;

endmodule

>>> design/mbc3_bank_address_mapper_top.sv
// MBC3 bank address mapper.
// req_ch carries one guest CPU byte access per word (mode, address, write_data).
// rsp_ch returns one result word per access: action, host_address, io_port and
// store_data. csr_ch writes the region bases and controller kind; it is always
// ready and must only be used while no access is in flight.
// A word accepted from req_ch passes the two-register path (input register,
// decode/add, result register) to rsp_ch. Throughput: one word per cycle
// while rsp_ch is ready; the bank registers update as the access moves into
// the result register, so the following access sees them at once.
// When rsp_ch stalls, the result register holds and the input register still
// takes one more word; req_ch.ready drops only when both are full.
// Reset (synchronous, active high) empties both registers, restores the
// default bases and MBC3 kind, ROM bank 1, RAM bank 0 mapped, RAM disabled.
module mbc3_bank_address_mapper_top (
   input logic           clock,
   input logic           reset,
   mbc3m_req_intf.sink   req_ch,
   mbc3m_rsp_intf.source rsp_ch,
   mbc3m_csr_intf.sink   csr_ch
);

   mbc3m_pkg::cfg_type        cfg;
   mbc3m_pkg::bank_state_type bank;
   mbc3m_pkg::bank_wr_type    bank_wr_raw;
   mbc3m_pkg::bank_wr_type    bank_wr;
   mbc3m_pkg::rsp_word_type   rsp_word;

   // input register
   logic                    in_valid_ff;
   logic                    in_valid_in;
   mbc3m_pkg::req_word_type in_word_ff;
   mbc3m_pkg::req_word_type in_word_in;

   // result register
   logic                    out_valid_ff;
   logic                    out_valid_in;
   mbc3m_pkg::rsp_word_type out_word_ff;
   mbc3m_pkg::rsp_word_type out_word_in;

   logic advance;
   logic req_take;

   assign csr_ch.ready = 1'b1;

   mbc3m_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.data),
      .cfg      (cfg)
   );

   mbc3m_translate u_translate (
      .cfg      (cfg),
      .bank     (bank),
      .req_word (in_word_ff),
      .rsp_word (rsp_word),
      .bank_wr  (bank_wr_raw)
   );

   // bank registers only change when the access actually moves on
   always_comb begin
      bank_wr       = bank_wr_raw;
      bank_wr.valid = bank_wr_raw.valid && advance;
   end

   mbc3m_bank_state u_bank_state (
      .clock   (clock),
      .reset   (reset),
      .bank_wr (bank_wr),
      .bank    (bank)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_word_in  = in_word_ff;
      if (req_take) begin
         in_valid_in           = 1'b1;
         in_word_in.mode       = req_ch.mode;
         in_word_in.address    = req_ch.address;
         in_word_in.write_data = req_ch.write_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_word_in  = out_word_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_word_in  = rsp_word;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff  <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.action       = out_word_ff.action;
   assign rsp_ch.host_address = out_word_ff.host_address;
   assign rsp_ch.io_port      = out_word_ff.io_port;
   assign rsp_ch.store_data   = out_word_ff.store_data;

endmodule
